@@ design/tcba_pkg.sv @@
// Shared types and constants of the two-class block allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tcba_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 16;
    localparam int MODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int OP_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC,
        MODE_FREE,
        MODE_REINIT,
        MODE_UNUSED
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_TOO_LARGE,
        ST_EXHAUSTED,
        ST_OUTSIDE
    } status_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_S,
        OP_ALLOC_L,
        OP_FREE_S,
        OP_FREE_L,
        OP_REINIT,
        OP_TOO_BIG,
        OP_OUTSIDE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_SPLIT,
        F_DIV
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_ALLOC
    } back_state_t;

    typedef enum logic [1:0] {
        TAKE_POP,
        TAKE_FRESH,
        TAKE_NONE
    } take_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

@@ design/tcba_front.sv @@
// Front end: accepts requests, checks size and region, and turns a free address
// into a block index by reciprocal multiplication. Depends on tcba_pkg.
`default_nettype none

module tcba_front import tcba_pkg::*; #(
    parameter int SMALL_BLOCKS = 1024,
    parameter int LARGE_BLOCKS = 256,
    parameter int SMALL_BLOCK_BYTES = 256,
    parameter int LARGE_BLOCK_BYTES = 4224,
    localparam int SIW = $clog2(SMALL_BLOCKS),
    localparam int LIW = $clog2(LARGE_BLOCKS),
    localparam int QW = (SIW > LIW) ? SIW : LIW
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [MODE_W-1:0]   s_mode,
    input  wire logic [SIZE_W-1:0]   s_request_size,
    input  wire logic [ADDR_W-1:0]   s_block_address,
    input  wire logic [ADDR_W-1:0]   region_base,
    input  wire fifo_status_t        fifo_st,
    output logic                     push,
    output op_t                      push_op,
    output logic [QW-1:0]            push_idx
);

    localparam logic [63:0] SMALL_BYTES = 64'(SMALL_BLOCKS) * 64'(SMALL_BLOCK_BYTES);
    localparam logic [63:0] TOTAL_BYTES =
        SMALL_BYTES + 64'(LARGE_BLOCKS) * 64'(LARGE_BLOCK_BYTES);
    localparam int OW = $clog2(TOTAL_BYTES);
    localparam int SDB = $clog2(SMALL_BLOCK_BYTES);
    localparam int LDB = $clog2(LARGE_BLOCK_BYTES);
    // quotient is exact for any offset below 2**OW with this shift
    localparam int RSH = OW + ((SDB > LDB) ? SDB : LDB);
    localparam logic [63:0] S_RECIP =
        ((64'd1 << RSH) + 64'(SMALL_BLOCK_BYTES) - 64'd1) / 64'(SMALL_BLOCK_BYTES);
    localparam logic [63:0] L_RECIP =
        ((64'd1 << RSH) + 64'(LARGE_BLOCK_BYTES) - 64'd1) / 64'(LARGE_BLOCK_BYTES);
    localparam int MW = $clog2(((S_RECIP > L_RECIP) ? S_RECIP : L_RECIP) + 64'd1);
    localparam int PW = (OW + MW > RSH + QW) ? OW + MW : RSH + QW;
    localparam logic [ADDR_W-1:0] TOTAL_A = ADDR_W'(TOTAL_BYTES);
    localparam logic [OW-1:0] SMALL_OFF = OW'(SMALL_BYTES);
    localparam logic [SIZE_W-1:0] SBB = SIZE_W'(SMALL_BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] LBB = SIZE_W'(LARGE_BLOCK_BYTES);

    front_state_t        state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [OW-1:0]       off_reg, off_next;
    logic [OW-1:0]       rem_reg, rem_next;
    logic                large_reg, large_next;

    logic [ADDR_W:0]     diff;
    logic                outside;
    logic                split_large;
    logic [MW-1:0]       recip;
    logic [PW-1:0]       prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        size_reg  <= size_next;
        addr_reg  <= addr_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        large_reg <= large_next;
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        large_next = large_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        push_op    = OP_NOP;
        push_idx   = '0;

        diff        = {1'b0, addr_reg} - {1'b0, region_base};
        outside     = diff[ADDR_W] || (diff[ADDR_W-1:0] >= TOTAL_A);
        split_large = off_reg >= SMALL_OFF;
        recip       = large_reg ? MW'(L_RECIP) : MW'(S_RECIP);
        prod        = PW'(rem_reg) * PW'(recip);

        unique case (state_reg)
            F_IDLE: begin
                s_ready = !fifo_st.full;
                if (s_valid && !fifo_st.full) begin
                    mode_next  = mode_t'(s_mode);
                    size_next  = s_request_size;
                    addr_next  = s_block_address;
                    state_next = F_CLASS;
                end
            end
            F_CLASS: begin
                unique case (mode_reg)
                    MODE_ALLOC: begin
                        push = 1'b1;
                        if (size_reg > LBB) begin
                            push_op = OP_TOO_BIG;
                        end else if (size_reg > SBB) begin
                            push_op = OP_ALLOC_L;
                        end else begin
                            push_op = OP_ALLOC_S;
                        end
                        state_next = F_IDLE;
                    end
                    MODE_FREE: begin
                        if (outside) begin
                            push       = 1'b1;
                            push_op    = OP_OUTSIDE;
                            state_next = F_IDLE;
                        end else begin
                            off_next   = diff[OW-1:0];
                            state_next = F_SPLIT;
                        end
                    end
                    MODE_REINIT: begin
                        push       = 1'b1;
                        push_op    = OP_REINIT;
                        state_next = F_IDLE;
                    end
                    MODE_UNUSED: begin
                        push       = 1'b1;
                        push_op    = OP_NOP;
                        state_next = F_IDLE;
                    end
                endcase
            end
            F_SPLIT: begin
                large_next = split_large;
                rem_next   = split_large ? (off_reg - SMALL_OFF) : off_reg;
                state_next = F_DIV;
            end
            F_DIV: begin
                push       = 1'b1;
                push_op    = large_reg ? OP_FREE_L : OP_FREE_S;
                push_idx   = prod[RSH +: QW];
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/tcba_cmd_fifo.sv @@
// Two-entry command queue between the front end and the pool engine.
// Depends on tcba_pkg for the status struct.
`default_nettype none

module tcba_cmd_fifo import tcba_pkg::*; #(
    parameter int DATA_W = 13
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] din,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      dout,
    output fifo_status_t           st
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_push, do_pop;

    always_comb begin
        st.full     = cnt_reg == 2'd2;
        st.empty    = cnt_reg == 2'd0;
        do_push     = push && !st.full;
        do_pop      = pop && !st.empty;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        dout        = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ design/tcba_back.sv @@
// Pool engine: free lists, fresh counters, link memories and the result register.
// Depends on tcba_pkg.
`default_nettype none

module tcba_back import tcba_pkg::*; #(
    parameter int SMALL_BLOCKS = 1024,
    parameter int LARGE_BLOCKS = 256,
    parameter int SMALL_BLOCK_BYTES = 256,
    parameter int LARGE_BLOCK_BYTES = 4224,
    localparam int SIW = $clog2(SMALL_BLOCKS),
    localparam int LIW = $clog2(LARGE_BLOCKS),
    localparam int QW = (SIW > LIW) ? SIW : LIW
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [ADDR_W-1:0]   region_base,
    input  wire fifo_status_t        fifo_st,
    input  wire op_t                 cmd_op,
    input  wire logic [QW-1:0]       cmd_idx,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [ADDR_W-1:0]        m_granted_address,
    output logic                     m_from_large_pool
);

    localparam logic [63:0] SMALL_BYTES = 64'(SMALL_BLOCKS) * 64'(SMALL_BLOCK_BYTES);
    localparam logic [63:0] TOTAL_BYTES =
        SMALL_BYTES + 64'(LARGE_BLOCKS) * 64'(LARGE_BLOCK_BYTES);
    localparam int OW = $clog2(TOTAL_BYTES);
    localparam int PW = QW + SIZE_W;
    localparam int SCW = $clog2(SMALL_BLOCKS + 1);
    localparam int LCW = $clog2(LARGE_BLOCKS + 1);
    localparam logic [OW-1:0] SMALL_OFF = OW'(SMALL_BYTES);
    localparam logic [SCW-1:0] S_N = SCW'(SMALL_BLOCKS);
    localparam logic [LCW-1:0] L_N = LCW'(LARGE_BLOCKS);
    localparam logic [SIZE_W-1:0] SBB = SIZE_W'(SMALL_BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] LBB = SIZE_W'(LARGE_BLOCK_BYTES);

    back_state_t        state_reg, state_next;
    logic [SIW-1:0]     s_head_reg, s_head_next;
    logic [SCW-1:0]     s_cnt_reg, s_cnt_next;
    logic [SCW-1:0]     s_fresh_reg, s_fresh_next;
    logic [LIW-1:0]     l_head_reg, l_head_next;
    logic [LCW-1:0]     l_cnt_reg, l_cnt_next;
    logic [LCW-1:0]     l_fresh_reg, l_fresh_next;
    take_t              take_reg, take_next;
    logic               large_reg, large_next;
    logic [OW-1:0]      prod_reg, prod_next;

    logic [SIW-1:0]     s_link_mem [SMALL_BLOCKS];
    logic [LIW-1:0]     l_link_mem [LARGE_BLOCKS];
    logic [SIW-1:0]     s_rd_reg;
    logic [LIW-1:0]     l_rd_reg;
    logic               s_we, s_re, l_we, l_re;
    logic [SIW-1:0]     s_waddr, s_wdata, s_raddr;
    logic [LIW-1:0]     l_waddr, l_wdata, l_raddr;

    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  granted_reg, granted_next;
    logic               from_large_reg, from_large_next;

    logic               out_free, load;
    logic [SIW-1:0]     s_blk;
    logic [LIW-1:0]     l_blk;
    logic [QW-1:0]      mul_blk;
    logic [SIZE_W-1:0]  mul_k;
    logic [PW-1:0]      prod_full;

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_granted_address = granted_reg;
    assign m_from_large_pool = from_large_reg;

    always_ff @(posedge aclk) begin
        if (s_we) begin
            s_link_mem[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            s_rd_reg <= s_link_mem[s_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (l_we) begin
            l_link_mem[l_waddr] <= l_wdata;
        end
        if (l_re) begin
            l_rd_reg <= l_link_mem[l_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            s_head_reg  <= '0;
            s_cnt_reg   <= '0;
            s_fresh_reg <= '0;
            l_head_reg  <= '0;
            l_cnt_reg   <= '0;
            l_fresh_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_head_reg  <= s_head_next;
            s_cnt_reg   <= s_cnt_next;
            s_fresh_reg <= s_fresh_next;
            l_head_reg  <= l_head_next;
            l_cnt_reg   <= l_cnt_next;
            l_fresh_reg <= l_fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        take_reg       <= take_next;
        large_reg      <= large_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        from_large_reg <= from_large_next;
    end

    always_comb begin
        state_next      = state_reg;
        s_head_next     = s_head_reg;
        s_cnt_next      = s_cnt_reg;
        s_fresh_next    = s_fresh_reg;
        l_head_next     = l_head_reg;
        l_cnt_next      = l_cnt_reg;
        l_fresh_next    = l_fresh_reg;
        take_next       = take_reg;
        large_next      = large_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        from_large_next = from_large_reg;
        pop             = 1'b0;
        load            = 1'b0;
        s_we            = 1'b0;
        s_re            = 1'b0;
        l_we            = 1'b0;
        l_re            = 1'b0;
        s_waddr         = cmd_idx[SIW-1:0];
        s_wdata         = s_head_reg;
        s_raddr         = s_head_reg;
        l_waddr         = cmd_idx[LIW-1:0];
        l_wdata         = l_head_reg;
        l_raddr         = l_head_reg;

        out_free = !m_valid_reg || m_ready;
        s_blk    = (s_cnt_reg != '0) ? s_head_reg : s_fresh_reg[SIW-1:0];
        l_blk    = (l_cnt_reg != '0) ? l_head_reg : l_fresh_reg[LIW-1:0];

        // offset of the block about to be handed out, registered before the base add
        mul_blk   = (cmd_op == OP_ALLOC_L) ? QW'(l_blk) : QW'(s_blk);
        mul_k     = (cmd_op == OP_ALLOC_L) ? LBB : SBB;
        prod_full = PW'(mul_blk) * PW'(mul_k);
        prod_next = OW'(prod_full) + ((cmd_op == OP_ALLOC_L) ? SMALL_OFF : '0);

        unique case (state_reg)
            B_IDLE: begin
                if (!fifo_st.empty) begin
                    unique case (cmd_op)
                        OP_ALLOC_S: begin
                            pop        = 1'b1;
                            large_next = 1'b0;
                            state_next = B_ALLOC;
                            if (s_cnt_reg != '0) begin
                                s_re       = 1'b1;
                                s_cnt_next = s_cnt_reg - 1'b1;
                                take_next  = TAKE_POP;
                            end else if (s_fresh_reg < S_N) begin
                                s_fresh_next = s_fresh_reg + 1'b1;
                                take_next    = TAKE_FRESH;
                            end else begin
                                take_next = TAKE_NONE;
                            end
                        end
                        OP_ALLOC_L: begin
                            pop        = 1'b1;
                            large_next = 1'b1;
                            state_next = B_ALLOC;
                            if (l_cnt_reg != '0) begin
                                l_re       = 1'b1;
                                l_cnt_next = l_cnt_reg - 1'b1;
                                take_next  = TAKE_POP;
                            end else if (l_fresh_reg < L_N) begin
                                l_fresh_next = l_fresh_reg + 1'b1;
                                take_next    = TAKE_FRESH;
                            end else begin
                                take_next = TAKE_NONE;
                            end
                        end
                        OP_FREE_S: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                s_we            = 1'b1;
                                s_head_next     = cmd_idx[SIW-1:0];
                                if (s_cnt_reg < S_N) begin
                                    s_cnt_next = s_cnt_reg + 1'b1;
                                end
                                status_next     = ST_OK;
                                granted_next    = '0;
                                from_large_next = 1'b0;
                            end
                        end
                        OP_FREE_L: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                l_we            = 1'b1;
                                l_head_next     = cmd_idx[LIW-1:0];
                                if (l_cnt_reg < L_N) begin
                                    l_cnt_next = l_cnt_reg + 1'b1;
                                end
                                status_next     = ST_OK;
                                granted_next    = '0;
                                from_large_next = 1'b1;
                            end
                        end
                        OP_REINIT: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                s_head_next     = '0;
                                s_cnt_next      = '0;
                                s_fresh_next    = '0;
                                l_head_next     = '0;
                                l_cnt_next      = '0;
                                l_fresh_next    = '0;
                                status_next     = ST_OK;
                                granted_next    = '0;
                                from_large_next = 1'b0;
                            end
                        end
                        OP_TOO_BIG: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                status_next     = ST_TOO_LARGE;
                                granted_next    = '0;
                                from_large_next = 1'b0;
                            end
                        end
                        OP_OUTSIDE: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                status_next     = ST_OUTSIDE;
                                granted_next    = '0;
                                from_large_next = 1'b0;
                            end
                        end
                        OP_NOP: begin
                            if (out_free) begin
                                pop             = 1'b1;
                                load            = 1'b1;
                                status_next     = ST_OK;
                                granted_next    = '0;
                                from_large_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            B_ALLOC: begin
                prod_next = prod_reg;
                if (out_free) begin
                    load            = 1'b1;
                    from_large_next = large_reg;
                    state_next      = B_IDLE;
                    case (take_reg)
                        TAKE_POP: begin
                            status_next  = ST_OK;
                            granted_next = region_base + ADDR_W'(prod_reg);
                            if (large_reg) begin
                                l_head_next = l_rd_reg;
                            end else begin
                                s_head_next = s_rd_reg;
                            end
                        end
                        TAKE_FRESH: begin
                            status_next  = ST_OK;
                            granted_next = region_base + ADDR_W'(prod_reg);
                        end
                        default: begin
                            status_next  = ST_EXHAUSTED;
                            granted_next = '0;
                        end
                    endcase
                end
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/two_class_block_allocator_top.sv @@
// Flow: a reinit, a rejected request or an unused mode is decoded in F_CLASS, queued, and
// its result registered by the pool engine; an allocate also passes B_ALLOC, with a link
// memory read when it pops a free list; a free in range also passes F_SPLIT (offset split)
// and F_DIV (reciprocal multiply for the block index); any result stall holds the flow.
// The front end takes a new request only after it has queued the last one.
// Reset: synchronous, active low; pools empty, region_base zero, link memories untouched.
// Top level of the two-class block allocator. Depends on tcba_pkg, tcba_front,
// tcba_cmd_fifo and tcba_back.
`default_nettype none

module two_class_block_allocator_top import tcba_pkg::*; #(
    parameter int SMALL_BLOCKS = 1024,
    parameter int LARGE_BLOCKS = 256,
    parameter int SMALL_BLOCK_BYTES = 256,
    parameter int LARGE_BLOCK_BYTES = 4224
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [ADDR_W-1:0]   cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [MODE_W-1:0]   s_mode,
    input  wire logic [SIZE_W-1:0]   s_request_size,
    input  wire logic [ADDR_W-1:0]   s_block_address,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [ADDR_W-1:0]        m_granted_address,
    output logic                     m_from_large_pool
);

    localparam int SIW = $clog2(SMALL_BLOCKS);
    localparam int LIW = $clog2(LARGE_BLOCKS);
    localparam int QW = (SIW > LIW) ? SIW : LIW;
    localparam int CMD_W = OP_W + QW;

    logic [ADDR_W-1:0] base_reg;
    fifo_status_t      fifo_st;
    logic              push, pop;
    op_t               push_op;
    logic [QW-1:0]     push_idx;
    logic [CMD_W-1:0]  fifo_dout;
    op_t               cmd_op;
    logic [QW-1:0]     cmd_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    assign cmd_op  = op_t'(fifo_dout[CMD_W-1:QW]);
    assign cmd_idx = fifo_dout[QW-1:0];

    tcba_front #(
        .SMALL_BLOCKS      (SMALL_BLOCKS),
        .LARGE_BLOCKS      (LARGE_BLOCKS),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_request_size  (s_request_size),
        .s_block_address (s_block_address),
        .region_base     (base_reg),
        .fifo_st         (fifo_st),
        .push            (push),
        .push_op         (push_op),
        .push_idx        (push_idx)
    );

    tcba_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     ({push_op, push_idx}),
        .pop     (pop),
        .dout    (fifo_dout),
        .st      (fifo_st)
    );

    tcba_back #(
        .SMALL_BLOCKS      (SMALL_BLOCKS),
        .LARGE_BLOCKS      (LARGE_BLOCKS),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .region_base       (base_reg),
        .fifo_st           (fifo_st),
        .cmd_op            (cmd_op),
        .cmd_idx           (cmd_idx),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_from_large_pool (m_from_large_pool)
    );

endmodule

`default_nettype wire

@@ design/tcba_checker.sv @@
// Port-level checks of the two-class block allocator, bound to the top level.
// Depends on tcba_pkg.
`default_nettype none

module tcba_checker import tcba_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_wr_en,
    input wire logic [ADDR_W-1:0]   cfg_wr_data,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic [MODE_W-1:0]   s_mode,
    input wire logic [SIZE_W-1:0]   s_request_size,
    input wire logic [ADDR_W-1:0]   s_block_address,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic [ADDR_W-1:0]   m_granted_address,
    input wire logic                m_from_large_pool
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_granted_address) && $stable(m_from_large_pool))
        else $error("result changed while stalled");

    a_no_addr_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_granted_address == '0)
        else $error("address given with a failing status");

    a_reject_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_TOO_LARGE || m_status == ST_OUTSIDE)
            |-> !m_from_large_pool)
        else $error("rejected request flagged as large pool");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still decoding");

endmodule

bind two_class_block_allocator_top tcba_checker u_tcba_checker (.*);

`default_nettype wire
